### sv/bpl_pkg.sv
// package with operation and status codes and default sizes for the positional list
`default_nettype none
package bpl_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int OP_W     = 2;
  localparam int POS_W    = 5;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_DELETE = 2'd1;
  localparam op_t OP_DUMP   = 2'd2;

  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_FULL = 2'd1;
  localparam status_t ST_BAD  = 2'd2;

endpackage
`default_nettype wire

### sv/bpl_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none
module bpl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### sv/bounded_positional_list.sv
// Bounded positional list: ordered store of up to CAPACITY values with insert, delete, dump.
//
// One input channel (in_valid/in_stall) takes op, position and value; one output
// channel (out_valid/out_stall) gives status, element, count_now and last.
// The block takes one item at a time: in_stall is high from the transfer of an
// item until its last result has been loaded into the output register, so the
// next item can be taken while that result still waits on out_stall.
// Insert at position p into a list of n shifts n-p+1 entries one per cycle
// through the single ram port pair, then writes the new value. Delete at
// position p shifts n-p entries. Dump gives n results, one per cycle while
// out_stall is low, after the registered ram read. Refused operations go
// straight to their single result.
// A stalled output holds its result and the sequencer waits on it.
// Reset (rst, synchronous) empties the list and drops any result not yet taken;
// the ram itself is not cleared, entries are only read once written.
`default_nettype none
module bounded_positional_list #(
  parameter int CAPACITY   = bpl_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = bpl_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [bpl_pkg::OP_W-1:0]      op,
  input  wire logic [bpl_pkg::POS_W-1:0]     position,
  input  wire logic signed [bpl_pkg::VALUE_W-1:0] value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [bpl_pkg::STATUS_W-1:0]       status,
  output logic signed [bpl_pkg::VALUE_W-1:0] element,
  output logic [bpl_pkg::COUNT_W-1:0]        count_now,
  output logic                               last
);
  import bpl_pkg::*;

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int IW   = CW + 1;
  localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_INS_SHIFT = 3'd1;
  localparam logic [2:0] S_INS_WRITE = 3'd2;
  localparam logic [2:0] S_DEL_SHIFT = 3'd3;
  localparam logic [2:0] S_DUMP      = 3'd4;
  localparam logic [2:0] S_RESP      = 3'd5;

  logic [2:0]            state;
  logic [CW-1:0]         count;
  logic [CW-1:0]         idx;
  logic [CW-1:0]         tgt;
  logic [DATA_WIDTH-1:0] value_reg;
  status_t               resp_status;

  logic                  rd_en, wr_en;
  logic [AW-1:0]         rd_addr, wr_addr;
  logic [DATA_WIDTH-1:0] wr_data, rd_data;

  logic            accept, out_free, load_out;
  logic [CMPW-1:0] pos_ext, cnt_ext;
  logic            is_full, ins_pos_ok, del_pos_ok;
  logic [CW-1:0]   tgt_in;
  logic [IW-1:0]   idx_w, tgt_w, cnt_w;
  logic            ins_more, del_more, dump_last;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign load_out = out_free && (state == S_DUMP || state == S_RESP);

  assign pos_ext    = CMPW'(position);
  assign cnt_ext    = CMPW'(count);
  assign is_full    = (count >= CW'(CAPACITY));
  assign ins_pos_ok = (pos_ext != '0) && (pos_ext <= cnt_ext + CMPW'(1));
  assign del_pos_ok = (count != '0) && (pos_ext != '0) && (pos_ext <= cnt_ext);
  assign tgt_in     = CW'(pos_ext - CMPW'(1));

  assign idx_w     = IW'(idx);
  assign tgt_w     = IW'(tgt);
  assign cnt_w     = IW'(count);
  assign ins_more  = (idx_w > tgt_w + IW'(1));
  assign del_more  = (idx_w + IW'(2) < cnt_w);
  assign dump_last = (idx_w + IW'(1) == cnt_w);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = idx[AW-1:0];
    wr_data = rd_data;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (op == OP_INSERT && !is_full && ins_pos_ok && pos_ext <= cnt_ext) begin
            rd_en   = 1'b1;
            rd_addr = AW'(count - CW'(1));
          end else if (op == OP_DELETE && del_pos_ok && pos_ext < cnt_ext) begin
            rd_en   = 1'b1;
            rd_addr = AW'(tgt_in + CW'(1));
          end else if (op == OP_DUMP && count != '0) begin
            rd_en   = 1'b1;
            rd_addr = '0;
          end
        end
      end
      S_INS_SHIFT: begin
        wr_en = 1'b1;
        if (ins_more) begin
          rd_en   = 1'b1;
          rd_addr = AW'(idx - CW'(2));
        end
      end
      S_INS_WRITE: begin
        wr_en   = 1'b1;
        wr_addr = tgt[AW-1:0];
        wr_data = value_reg;
      end
      S_DEL_SHIFT: begin
        wr_en = 1'b1;
        if (del_more) begin
          rd_en   = 1'b1;
          rd_addr = AW'(idx_w + IW'(2));
        end
      end
      S_DUMP: begin
        if (out_free && !dump_last) begin
          rd_en   = 1'b1;
          rd_addr = AW'(idx + CW'(1));
        end
      end
      S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  bpl_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !load_out) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (op)
              OP_INSERT: begin
                if (is_full) begin
                  resp_status <= ST_FULL;
                  state       <= S_RESP;
                end else if (!ins_pos_ok) begin
                  resp_status <= ST_BAD;
                  state       <= S_RESP;
                end else begin
                  tgt       <= tgt_in;
                  idx       <= count;
                  value_reg <= DATA_WIDTH'($unsigned(value));
                  state     <= (pos_ext <= cnt_ext) ? S_INS_SHIFT : S_INS_WRITE;
                end
              end
              OP_DELETE: begin
                if (!del_pos_ok) begin
                  resp_status <= ST_BAD;
                  state       <= S_RESP;
                end else if (pos_ext < cnt_ext) begin
                  idx   <= tgt_in;
                  state <= S_DEL_SHIFT;
                end else begin
                  count       <= count - CW'(1);
                  resp_status <= ST_OK;
                  state       <= S_RESP;
                end
              end
              OP_DUMP: begin
                if (count == '0) begin
                  resp_status <= ST_BAD;
                  state       <= S_RESP;
                end else begin
                  idx   <= '0;
                  state <= S_DUMP;
                end
              end
              default: begin
                resp_status <= ST_BAD;
                state       <= S_RESP;
              end
            endcase
          end
        end
        S_INS_SHIFT: begin
          idx <= idx - CW'(1);
          if (!ins_more) begin
            state <= S_INS_WRITE;
          end
        end
        S_INS_WRITE: begin
          count       <= count + CW'(1);
          resp_status <= ST_OK;
          state       <= S_RESP;
        end
        S_DEL_SHIFT: begin
          idx <= idx + CW'(1);
          if (!del_more) begin
            count       <= count - CW'(1);
            resp_status <= ST_OK;
            state       <= S_RESP;
          end
        end
        S_DUMP: begin
          if (out_free) begin
            out_valid <= 1'b1;
            status    <= ST_OK;
            element   <= VALUE_W'(signed'(rd_data));
            count_now <= COUNT_W'(count);
            last      <= dump_last;
            if (dump_last) begin
              state <= S_IDLE;
            end else begin
              idx <= idx + CW'(1);
            end
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_valid <= 1'b1;
            status    <= resp_status;
            element   <= '0;
            count_now <= COUNT_W'(count);
            last      <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### sv/bpl_checker.sv
// port-level checker for the positional list, bound to the top level
`default_nettype none
module bpl_checker #(
  parameter int CAPACITY = bpl_pkg::CAPACITY_DEF
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [bpl_pkg::STATUS_W-1:0]  status,
  input wire logic signed [bpl_pkg::VALUE_W-1:0] element,
  input wire logic [bpl_pkg::COUNT_W-1:0]   count_now,
  input wire logic                          last
);
  import bpl_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(element)
      && $stable(count_now) && $stable(last))
    else $error("stalled result changed");

  // one item at a time: busy right after a transfer in
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while previous item in progress");

  // refused operations give a single zero result
  a_refused_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> last && element == '0)
    else $error("error result not final or element not zero");

  // count never exceeds capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (CAPACITY > 31) || (count_now <= COUNT_W'(CAPACITY)))
    else $error("count above capacity");

endmodule

bind bounded_positional_list bpl_checker #(.CAPACITY(CAPACITY)) u_bpl_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .status    (status),
  .element   (element),
  .count_now (count_now),
  .last      (last)
);
`default_nettype wire
